FILE: hdl/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants for the fern point generator
// Fixed-point formats, map coefficient table, register indexes and the
// entry that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package ifs_pkg;

	// Fixed point: FRAC_BITS fraction bits, point holds 8 integer bits
	localparam int FRAC_BITS  = 16;
	localparam int POINT_BITS = FRAC_BITS + 8;
	// Largest coefficient is 1.60, so one integer bit plus sign
	localparam int COEF_W     = FRAC_BITS + 2;

	// Field widths
	localparam int THR_W     = 10;
	localparam int COLOUR_W  = 4;
	localparam int PIX_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Pixel range and row origin
	localparam int PIX_MAX  = 1023;
	localparam int PIX_MIN  = -1024;
	localparam int ROW_BASE = 240;

	// Threshold values after reset
	localparam logic [THR_W-1:0] FIRST_THR_RST  = THR_W'(10);
	localparam logic [THR_W-1:0] SECOND_THR_RST = THR_W'(860);
	localparam logic [THR_W-1:0] THIRD_THR_RST  = THR_W'(930);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_THR  = 2'd0,
		CFG_SECOND_THR = 2'd1,
		CFG_THIRD_THR  = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		MAP_STEM  = 2'd0,
		MAP_MAIN  = 2'd1,
		MAP_LEFT  = 2'd2,
		MAP_RIGHT = 2'd3
	} map_sel_t;

	typedef struct packed {
		map_sel_t              map;
		logic [COLOUR_W-1:0]   colour;
	} queue_entry_t;

	// x' = a*x + b*y + e ; y' = c*x + d*y + f
	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] e;
		logic signed [COEF_W-1:0] f;
	} coef_set_t;

	// Hundredths to fixed point, halves rounded away from zero
	function automatic logic signed [COEF_W-1:0] coef_fixed(input int hund);
		longint mag;
		longint r;
		mag = (hund < 0) ? -longint'(hund) : longint'(hund);
		r   = (mag * (longint'(1) << FRAC_BITS) + 64'sd50) / 64'sd100;
		if (hund < 0) begin
			r = -r;
		end
		return COEF_W'(r);
	endfunction

	localparam coef_set_t MAP_COEF [4] = '{
		'{coef_fixed(0),   coef_fixed(0),   coef_fixed(0),
		  coef_fixed(16),  coef_fixed(0),   coef_fixed(0)},
		'{coef_fixed(85),  coef_fixed(4),   coef_fixed(-4),
		  coef_fixed(85),  coef_fixed(0),   coef_fixed(160)},
		'{coef_fixed(5),   coef_fixed(-26), coef_fixed(23),
		  coef_fixed(22),  coef_fixed(0),   coef_fixed(160)},
		'{coef_fixed(-15), coef_fixed(30),  coef_fixed(26),
		  coef_fixed(24),  coef_fixed(0),   coef_fixed(44)}
	};

endpackage

FILE: hdl/ifs_if.sv
// ----------------------------------------------------------------------------
// ifs_if: item channels of the fern point generator
// ifs_in_if carries selection value and colour in; ifs_out_if carries the
// plotted pixel out. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifs_in_if;
	logic                           valid;
	logic                           ready;
	logic [ifs_pkg::THR_W-1:0]      select_value;
	logic [ifs_pkg::COLOUR_W-1:0]   pixel_colour;

	modport source (output valid, output select_value, output pixel_colour, input ready);
	modport sink   (input valid, input select_value, input pixel_colour, output ready);
endinterface

interface ifs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ifs_pkg::PIX_W-1:0] column;
	logic signed [ifs_pkg::PIX_W-1:0] row;
	logic [ifs_pkg::COLOUR_W-1:0]     colour_out;

	modport source (output valid, output column, output row, output colour_out, input ready);
	modport sink   (input valid, input column, input row, input colour_out, output ready);
endinterface

FILE: hdl/ifs_fern_point_step.sv
// ----------------------------------------------------------------------------
// ifs_fern_point_step: fern point generator, one point per item
// Each item picks one of four affine maps from its selection value, moves
// the held point and yields the pixel where the new point is plotted.
//
// Channels: item (select_value, pixel_colour) in, pixel (column, row,
// colour_out) out, both valid/ready. Thresholds are written through the
// cfg_we / cfg_index / cfg_wdata port; the user must write them only while
// the block is idle; the block does not enforce it. An item passes the queue,
// the point update stage and the output register before its result is valid.
// Throughput: one item per cycle while pixel.ready is high; the point update
// (four multipliers and the rounding adders feeding the point registers) is
// combinational. A four-entry queue separates intake from the update path.
// Reset: point goes to the origin, thresholds to 10, 860 and 930, queue
// and pipeline empty.
// Stall: when the receiver holds ready low, the output register and stage 1
// hold, the queue fills and item.ready falls once it is full; nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module ifs_fern_point_step (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ifs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ifs_pkg::THR_W-1:0]        cfg_wdata,
	ifs_in_if.sink                           item,
	ifs_out_if.source                        pixel
);

	logic                    full;
	logic                    push;
	ifs_pkg::queue_entry_t   push_entry;
	logic                    pop;
	logic                    not_empty;
	ifs_pkg::queue_entry_t   head;

	// Intake and map selection
	ifs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item       (item),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decoupling queue
	ifs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Point update and pixel output
	ifs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.pixel      (pixel)
	);

endmodule

FILE: hdl/ifs_front.sv
// ----------------------------------------------------------------------------
// ifs_front: item intake and map selection
// Holds the threshold registers, compares each item's selection value and
// pushes the chosen map with the colour into the queue.
// ----------------------------------------------------------------------------
module ifs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ifs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ifs_pkg::THR_W-1:0]        cfg_wdata,
	ifs_in_if.sink                           item,
	input  logic                             full,
	output logic                             push,
	output ifs_pkg::queue_entry_t            push_entry
);

	logic [ifs_pkg::THR_W-1:0] first_thr_q;
	logic [ifs_pkg::THR_W-1:0] second_thr_q;
	logic [ifs_pkg::THR_W-1:0] third_thr_q;
	ifs_pkg::map_sel_t         map_sel;

	// Threshold registers; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_thr_q  <= ifs_pkg::FIRST_THR_RST;
			second_thr_q <= ifs_pkg::SECOND_THR_RST;
			third_thr_q  <= ifs_pkg::THIRD_THR_RST;
		end else if (cfg_we) begin
			case (ifs_pkg::cfg_index_t'(cfg_index))
				ifs_pkg::CFG_FIRST_THR:  first_thr_q  <= cfg_wdata;
				ifs_pkg::CFG_SECOND_THR: second_thr_q <= cfg_wdata;
				ifs_pkg::CFG_THIRD_THR:  third_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Ordered threshold tests, first hit wins
	always_comb begin
		if (item.select_value <= first_thr_q) begin
			map_sel = ifs_pkg::MAP_STEM;
		end else if (item.select_value <= second_thr_q) begin
			map_sel = ifs_pkg::MAP_MAIN;
		end else if (item.select_value <= third_thr_q) begin
			map_sel = ifs_pkg::MAP_LEFT;
		end else begin
			map_sel = ifs_pkg::MAP_RIGHT;
		end
	end

	// Take an item whenever the queue has room
	assign item.ready        = !full;
	assign push              = item.valid && !full;
	assign push_entry.map    = map_sel;
	assign push_entry.colour = item.pixel_colour;

endmodule

FILE: hdl/ifs_queue.sv
// ----------------------------------------------------------------------------
// ifs_queue: short FIFO between front and back
// Register-based queue of classified items; push and pop may happen in the
// same cycle.
// ----------------------------------------------------------------------------
module ifs_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ifs_pkg::queue_entry_t   push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output ifs_pkg::queue_entry_t   head
);

	ifs_pkg::queue_entry_t             mem_q [ifs_pkg::QUEUE_DEPTH];
	logic [ifs_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [ifs_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [ifs_pkg::QCNT_W-1:0]        count_q;

	localparam logic [ifs_pkg::QPTR_W-1:0] PTR_LAST = ifs_pkg::QPTR_W'(ifs_pkg::QUEUE_DEPTH - 1);
	localparam logic [ifs_pkg::QCNT_W-1:0] CNT_FULL = ifs_pkg::QCNT_W'(ifs_pkg::QUEUE_DEPTH);

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("count did not follow push");

endmodule

FILE: hdl/ifs_back.sv
// ----------------------------------------------------------------------------
// ifs_back: point update and pixel mapping
// Pops one classified item per cycle unless stalled, applies the chosen affine
// map to the held point, then converts the new point to a saturated pixel position.
// ----------------------------------------------------------------------------
module ifs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    not_empty,
	input  ifs_pkg::queue_entry_t   head,
	output logic                    pop,
	ifs_out_if.source               pixel
);

	localparam int PT_W   = ifs_pkg::POINT_BITS;
	localparam int PROD_W = ifs_pkg::POINT_BITS + ifs_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int PX_W   = ifs_pkg::POINT_BITS + 8;

	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (ifs_pkg::FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] PT_MAX = (ACC_W'(1) <<< (PT_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] PT_MIN = -(ACC_W'(1) <<< (PT_W - 1));

	localparam logic signed [PX_W-1:0] TRUNC_BIAS = (PX_W'(1) <<< ifs_pkg::FRAC_BITS) - PX_W'(1);
	localparam logic signed [PX_W-1:0] PX_MAX     = PX_W'(ifs_pkg::PIX_MAX);
	localparam logic signed [PX_W-1:0] PX_MIN     = PX_W'(ifs_pkg::PIX_MIN);
	localparam logic signed [PX_W-1:0] ROW_ORIGIN = PX_W'(ifs_pkg::ROW_BASE);

	// k0*x + k1*y rounded to FRAC_BITS, plus offset, saturated to point range
	function automatic logic signed [PT_W-1:0] affine_row(
		input logic signed [PT_W-1:0]            x,
		input logic signed [PT_W-1:0]            y,
		input logic signed [ifs_pkg::COEF_W-1:0] k0,
		input logic signed [ifs_pkg::COEF_W-1:0] k1,
		input logic signed [ifs_pkg::COEF_W-1:0] ke
	);
		logic signed [PROD_W-1:0] p0;
		logic signed [PROD_W-1:0] p1;
		logic signed [ACC_W-1:0]  s;
		logic signed [ACC_W-1:0]  t;
		p0 = x * k0;
		p1 = y * k1;
		s  = ACC_W'(p0) + ACC_W'(p1) + HALF;
		t  = (s >>> ifs_pkg::FRAC_BITS) + ACC_W'(ke);
		if (t > PT_MAX) begin
			t = PT_MAX;
		end else if (t < PT_MIN) begin
			t = PT_MIN;
		end
		return t[PT_W-1:0];
	endfunction

	// Divide by 2^FRAC_BITS rounding toward zero, then clamp to pixel range
	function automatic logic signed [PX_W-1:0] trunc_frac(input logic signed [PX_W-1:0] v);
		logic signed [PX_W-1:0] r;
		r = (v < 0) ? ((v + TRUNC_BIAS) >>> ifs_pkg::FRAC_BITS) : (v >>> ifs_pkg::FRAC_BITS);
		return r;
	endfunction

	function automatic logic signed [ifs_pkg::PIX_W-1:0] clamp_pix(input logic signed [PX_W-1:0] v);
		logic signed [PX_W-1:0] r;
		r = v;
		if (v > PX_MAX) begin
			r = PX_MAX;
		end else if (v < PX_MIN) begin
			r = PX_MIN;
		end
		return r[ifs_pkg::PIX_W-1:0];
	endfunction

	logic signed [PT_W-1:0]          point_x_q;
	logic signed [PT_W-1:0]          point_y_q;
	ifs_pkg::coef_set_t              coef;
	logic signed [PT_W-1:0]          next_x;
	logic signed [PT_W-1:0]          next_y;

	logic                            valid_s1;
	logic signed [PT_W-1:0]          x_s1;
	logic signed [PT_W-1:0]          y_s1;
	logic [ifs_pkg::COLOUR_W-1:0]    colour_s1;

	logic                            out_valid_q;
	logic signed [ifs_pkg::PIX_W-1:0] column_q;
	logic signed [ifs_pkg::PIX_W-1:0] row_q;
	logic [ifs_pkg::COLOUR_W-1:0]    colour_q;

	logic                            out_load;
	logic                            s1_load;
	logic signed [PX_W-1:0]          y_scaled;
	logic signed [PX_W-1:0]          x_scaled;

	// Stage flow: output register, then stage 1, then queue pop
	assign out_load = !out_valid_q || pixel.ready;
	assign s1_load  = !valid_s1 || out_load;
	assign pop      = not_empty && s1_load;

	// Affine map on the held point, four multipliers in parallel
	assign coef   = ifs_pkg::MAP_COEF[head.map];
	assign next_x = affine_row(point_x_q, point_y_q, coef.a, coef.b, coef.e);
	assign next_y = affine_row(point_x_q, point_y_q, coef.c, coef.d, coef.f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (pop) begin
			point_x_q <= next_x;
			point_y_q <= next_y;
		end
	end

	// Stage 1: new point and colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1      <= next_x;
			y_s1      <= next_y;
			colour_s1 <= head.colour;
		end
	end

	// Pixel scaling: y*64 and x*48 by shifts
	assign y_scaled = PX_W'(y_s1) <<< 6;
	assign x_scaled = (PX_W'(x_s1) <<< 5) + (PX_W'(x_s1) <<< 4);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			column_q <= clamp_pix(trunc_frac(y_scaled));
			row_q    <= clamp_pix(ROW_ORIGIN - trunc_frac(x_scaled));
			colour_q <= colour_s1;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.column     = column_q;
	assign pixel.row        = row_q;
	assign pixel.colour_out = colour_q;

endmodule
